[hw/rtl/obws_pkg.sv]
// Shared types and constants for the one-wire backlight sender.
// Used by obws_cfg, obws_seq and one_wire_backlight_sender_core.
package obws_pkg;

    localparam int FRAME_BITS = 8;
    localparam int CNT_W      = $clog2(FRAME_BITS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_HI_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_HI_LAST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR     = 3'd6;

    // Reset values of the registers.
    localparam logic [15:0] RST_SHORT_TIME   = 16'd10;
    localparam logic [15:0] RST_LONG_TIME    = 16'd180;
    localparam logic [15:0] RST_SEL_HI_FIRST = 16'd120;
    localparam logic [15:0] RST_SEL_LOW      = 16'd300;
    localparam logic [15:0] RST_SEL_HI_LAST  = 16'd600;
    localparam logic [15:0] RST_OFF_HOLD     = 16'd3000;
    localparam logic [7:0]  RST_DEV_ADDR     = 8'h72;

    localparam logic [7:0] MAX_LEVEL = 8'd32;
    localparam logic [4:0] DATA_MASK = 5'h1F;

    typedef struct packed {
        logic       panel_on;
        logic [7:0] level;
    } t_in;

    typedef struct packed {
        logic        line_level;
        logic [15:0] duration_us;
        logic        last_segment;
    } t_out;

    typedef struct packed {
        logic [15:0] short_time_us;
        logic [15:0] long_time_us;
        logic [15:0] select_high_first_us;
        logic [15:0] select_low_us;
        logic [15:0] select_high_last_us;
        logic [15:0] off_hold_us;
        logic [7:0]  device_address;
    } t_cfg;

endpackage

[hw/rtl/one_wire_backlight_sender_core.sv]
// One request takes 1 segment (panel off or level zero), 38 segments (two frames),
// or 41 with the mode-select sequence; the sequencer emits one segment per cycle
// while the output register can take it. A segment is registered in the sequencer
// state and then in the output register; the next request is taken the cycle after
// the last segment leaves the sequencer. Reset (synchronous, active low) restores
// register defaults and one-wire mode set. Depends on obws_pkg, obws_cfg, obws_seq.
module one_wire_backlight_sender_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [obws_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [obws_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  obws_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output obws_pkg::t_out                   o_out_data
);
    import obws_pkg::*;

    t_cfg cfg;
    t_out seg;
    logic seg_valid;
    logic adv;
    logic r_out_valid;
    t_out r_out;

    obws_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    obws_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_seg_valid (seg_valid),
        .o_seg       (seg),
        .i_adv       (adv)
    );

    // A segment moves into the output register whenever that register is free
    // or is being emptied in the same cycle.
    assign adv = seg_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out <= seg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/obws_cfg.sv]
// Configuration register file of the one-wire backlight sender.
// Depends on obws_pkg for register indexes, reset values and t_cfg.
module obws_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [obws_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [obws_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output obws_pkg::t_cfg                   o_cfg
);
    import obws_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_time_us        <= RST_SHORT_TIME;
            r_cfg.long_time_us         <= RST_LONG_TIME;
            r_cfg.select_high_first_us <= RST_SEL_HI_FIRST;
            r_cfg.select_low_us        <= RST_SEL_LOW;
            r_cfg.select_high_last_us  <= RST_SEL_HI_LAST;
            r_cfg.off_hold_us          <= RST_OFF_HOLD;
            r_cfg.device_address       <= RST_DEV_ADDR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT_TIME:   r_cfg.short_time_us        <= i_cfg_wdata;
                CFG_LONG_TIME:    r_cfg.long_time_us         <= i_cfg_wdata;
                CFG_SEL_HI_FIRST: r_cfg.select_high_first_us <= i_cfg_wdata;
                CFG_SEL_LOW:      r_cfg.select_low_us        <= i_cfg_wdata;
                CFG_SEL_HI_LAST:  r_cfg.select_high_last_us  <= i_cfg_wdata;
                CFG_OFF_HOLD:     r_cfg.off_hold_us          <= i_cfg_wdata;
                CFG_DEV_ADDR:     r_cfg.device_address       <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/obws_seq.sv]
// Segment sequencer: emits a single segment, or walks the select sequence and two
// frames, shifting the frame byte out one bit per pulse pair. Depends on obws_pkg.
module obws_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  obws_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  obws_pkg::t_in   i_in_data,
    output logic            o_seg_valid,
    output obws_pkg::t_out  o_seg,
    input  logic            i_adv
);
    import obws_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SINGLE  = 4'd1;
    localparam logic [3:0] ST_SEL_HI1 = 4'd2;
    localparam logic [3:0] ST_SEL_LO  = 4'd3;
    localparam logic [3:0] ST_SEL_HI2 = 4'd4;
    localparam logic [3:0] ST_START   = 4'd5;
    localparam logic [3:0] ST_BIT_LO  = 4'd6;
    localparam logic [3:0] ST_BIT_HI  = 4'd7;
    localparam logic [3:0] ST_END_LO  = 4'd8;
    localparam logic [3:0] ST_END_HI  = 4'd9;

    logic [3:0]            r_state, n_state;
    logic                  r_owa, n_owa;
    logic                  r_panel_off, n_panel_off;
    logic                  r_frame, n_frame;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [4:0]            r_data, n_data;

    logic       accept;
    logic       bit_val;
    logic [7:0] lvl_m1;

    assign accept  = i_in_valid && (r_state == ST_IDLE);
    assign bit_val = r_shift[FRAME_BITS-1];
    assign lvl_m1  = i_in_data.level - 8'd1;

    always_comb begin
        n_state     = r_state;
        n_owa       = r_owa;
        n_panel_off = r_panel_off;
        n_frame     = r_frame;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_data      = r_data;
        if (accept) begin
            n_frame = 1'b0;
            n_cnt   = '0;
            n_shift = i_cfg.device_address;
            if (!i_in_data.panel_on) begin
                n_panel_off = 1'b1;
                n_state     = ST_SINGLE;
            end else if (i_in_data.level == 8'd0) begin
                n_panel_off = 1'b0;
                n_owa       = 1'b0;
                n_state     = ST_SINGLE;
            end else begin
                // Levels above the top step all send the top data code.
                n_data  = (i_in_data.level >= MAX_LEVEL) ? DATA_MASK
                                                         : (lvl_m1[4:0] & DATA_MASK);
                n_owa   = 1'b1;
                n_state = r_owa ? ST_START : ST_SEL_HI1;
            end
        end else if (i_adv) begin
            case (r_state)
                ST_SINGLE:  n_state = ST_IDLE;
                ST_SEL_HI1: n_state = ST_SEL_LO;
                ST_SEL_LO:  n_state = ST_SEL_HI2;
                ST_SEL_HI2: n_state = ST_START;
                ST_START:   n_state = ST_BIT_LO;
                ST_BIT_LO:  n_state = ST_BIT_HI;
                ST_BIT_HI: begin
                    n_shift = {r_shift[FRAME_BITS-2:0], 1'b0};
                    n_cnt   = r_cnt + 1'b1;
                    n_state = (r_cnt == CNT_W'(FRAME_BITS - 1)) ? ST_END_LO : ST_BIT_LO;
                end
                ST_END_LO:  n_state = ST_END_HI;
                ST_END_HI: begin
                    if (!r_frame) begin
                        n_frame = 1'b1;
                        n_cnt   = '0;
                        n_shift = FRAME_BITS'(r_data);
                        n_state = ST_START;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                default:    n_state = ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_seg = '0;
        case (r_state)
            ST_SINGLE: begin
                o_seg.duration_us  = r_panel_off ? 16'd0 : i_cfg.off_hold_us;
                o_seg.last_segment = 1'b1;
            end
            ST_SEL_HI1: begin
                o_seg.line_level  = 1'b1;
                o_seg.duration_us = i_cfg.select_high_first_us;
            end
            ST_SEL_LO:  o_seg.duration_us = i_cfg.select_low_us;
            ST_SEL_HI2: begin
                o_seg.line_level  = 1'b1;
                o_seg.duration_us = i_cfg.select_high_last_us;
            end
            ST_START: begin
                o_seg.line_level  = 1'b1;
                o_seg.duration_us = i_cfg.short_time_us;
            end
            ST_BIT_LO: begin
                o_seg.duration_us = bit_val ? i_cfg.short_time_us : i_cfg.long_time_us;
            end
            ST_BIT_HI: begin
                o_seg.line_level  = 1'b1;
                o_seg.duration_us = bit_val ? i_cfg.long_time_us : i_cfg.short_time_us;
            end
            ST_END_LO:  o_seg.duration_us = i_cfg.short_time_us;
            ST_END_HI: begin
                // The closing high has zero duration and holds until the next segment.
                o_seg.line_level   = 1'b1;
                o_seg.last_segment = r_frame;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_owa       <= 1'b1;
            r_panel_off <= 1'b0;
            r_frame     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_owa       <= n_owa;
            r_panel_off <= n_panel_off;
            r_frame     <= n_frame;
            r_cnt       <= n_cnt;
        end
        r_shift <= n_shift;
        r_data  <= n_data;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_seg_valid = (r_state != ST_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after a transaction");

    a_sel_sets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEL_HI1) |-> r_owa)
        else $error("select sequence without mode re-entry");

    a_off_clears_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SINGLE && !r_panel_off) |-> !r_owa)
        else $error("level zero left one-wire mode set");

    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg.last_segment |-> (r_state == ST_SINGLE || (r_state == ST_END_HI && r_frame)))
        else $error("last segment flagged in the middle of a request");

endmodule

[bench/tb_one_wire_backlight_sender_core.sv]
// Testbench for one_wire_backlight_sender_core: brightness requests in, timed line segments out.
// Predicts each request's segments, checks them field by field, randomizes both handshakes.
// Depends on obws_pkg and the RTL of the core.
module tb_one_wire_backlight_sender_core;
    import obws_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    one_wire_backlight_sender_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state, mirrors of the registers and the one-wire mode flag.
    t_cfg timing;
    bit wire_mode_on;

    t_in request_q[$];
    t_out segment_q[$];
    t_out exp_seg;
    int errors = 0;
    int cycle_count = 0;

    // Sender burst state.
    int burst_left = 0;
    int gap_left = 0;

    // Receiver stall state.
    logic [15:0] ready_pat = 16'hFFFF;
    logic [3:0] pat_pos = '0;
    int hold_left = 0;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;

    function automatic void push_seg(logic lvl, logic [15:0] dur, logic is_last);
        t_out seg;
        seg.line_level = lvl;
        seg.duration_us = dur;
        seg.last_segment = is_last;
        segment_q.push_back(seg);
    endfunction

    function automatic void push_frame(logic [7:0] value, logic is_last);
        push_seg(1'b1, timing.short_time_us, 1'b0);
        for (int b = FRAME_BITS - 1; b >= 0; b--) begin
            if (value[b]) begin
                push_seg(1'b0, timing.short_time_us, 1'b0);
                push_seg(1'b1, timing.long_time_us, 1'b0);
            end else begin
                push_seg(1'b0, timing.long_time_us, 1'b0);
                push_seg(1'b1, timing.short_time_us, 1'b0);
            end
        end
        push_seg(1'b0, timing.short_time_us, 1'b0);
        push_seg(1'b1, 16'd0, is_last);
    endfunction

    function automatic void predict_segments(t_in req);
        logic [7:0] lvl;
        logic [7:0] code;
        lvl = req.level;
        if (!req.panel_on) begin
            push_seg(1'b0, 16'd0, 1'b1);
        end else begin
            if (lvl > MAX_LEVEL) lvl = MAX_LEVEL;
            if (lvl == 8'd0) begin
                push_seg(1'b0, timing.off_hold_us, 1'b1);
                wire_mode_on = 1'b0;
            end else begin
                if (!wire_mode_on) begin
                    push_seg(1'b1, timing.select_high_first_us, 1'b0);
                    push_seg(1'b0, timing.select_low_us, 1'b0);
                    push_seg(1'b1, timing.select_high_last_us, 1'b0);
                    wire_mode_on = 1'b1;
                end
                push_frame(timing.device_address, 1'b0);
                code = lvl - 8'd1;
                push_frame({3'b000, code[4:0] & DATA_MASK}, 1'b1);
            end
        end
    endfunction

    function automatic logic [15:0] rand_duration();
        case ($urandom_range(0, 3))
            0: rand_duration = 16'd0;
            1: rand_duration = 16'hFFFF;
            2: rand_duration = 16'($urandom_range(1, 255));
            default: rand_duration = 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_in rand_request();
        t_in req;
        req.panel_on = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 19))
            0, 1, 2, 3: req.level = 8'd0;
            4, 5, 6, 7, 8, 9, 10, 11: req.level = 8'($urandom_range(1, 32));
            12, 13, 14, 15, 16: req.level = 8'($urandom_range(33, 255));
            default: req.level = 8'($urandom_range(0, 255));
        endcase
        return req;
    endfunction

    task automatic queue_req(logic on, logic [7:0] lvl);
        t_in req;
        req.panel_on = on;
        req.level = lvl;
        request_q.push_back(req);
    endtask

    task automatic queue_random(int count);
        repeat (count) request_q.push_back(rand_request());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SHORT_TIME: timing.short_time_us = val;
            CFG_LONG_TIME: timing.long_time_us = val;
            CFG_SEL_HI_FIRST: timing.select_high_first_us = val;
            CFG_SEL_LOW: timing.select_low_us = val;
            CFG_SEL_HI_LAST: timing.select_high_last_us = val;
            CFG_OFF_HOLD: timing.off_hold_us = val;
            CFG_DEV_ADDR: timing.device_address = val[7:0];
            default: ;
        endcase
    endtask

    // Writes every register plus the unmapped index, which must have no effect.
    task automatic apply_config(logic [15:0] t_short, logic [15:0] t_long,
                                logic [15:0] t_hi1, logic [15:0] t_low,
                                logic [15:0] t_hi2, logic [15:0] t_off,
                                logic [15:0] addr);
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        write_reg(CFG_SHORT_TIME, t_short);
        write_reg(CFG_LONG_TIME, t_long);
        write_reg(CFG_SEL_HI_FIRST, t_hi1);
        write_reg(CFG_SEL_LOW, t_low);
        write_reg(CFG_SEL_HI_LAST, t_hi2);
        write_reg(CFG_OFF_HOLD, t_off);
        write_reg(CFG_DEV_ADDR, addr);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sampled on the falling edge so that the posedge processes have settled.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || segment_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_segments(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    i_in_data <= request_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = $urandom_range(0, 1) ? $urandom_range(1, 50) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Segment monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (segment_q.size() == 0) begin
                    $error("unexpected segment: line_level=%0d duration_us=%0d last_segment=%0d",
                           o_out_data.line_level, o_out_data.duration_us,
                           o_out_data.last_segment);
                    errors++;
                end else begin
                    exp_seg = segment_q.pop_front();
                    if (o_out_data.line_level !== exp_seg.line_level) begin
                        $error("line_level: expected %0d, actual %0d",
                               exp_seg.line_level, o_out_data.line_level);
                        errors++;
                    end
                    if (o_out_data.duration_us !== exp_seg.duration_us) begin
                        $error("duration_us: expected %0d, actual %0d",
                               exp_seg.duration_us, o_out_data.duration_us);
                        errors++;
                    end
                    if (o_out_data.last_segment !== exp_seg.last_segment) begin
                        $error("last_segment: expected %0d, actual %0d",
                               exp_seg.last_segment, o_out_data.last_segment);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_armed && !hold_done && o_out_valid) begin
                // Long hold-off while the sender keeps offering, so the core backs up.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ready_pat[pat_pos];
                if (pat_pos == 4'd15) begin
                    pat_pos = '0;
                    case ($urandom_range(0, 3))
                        0: ready_pat = 16'hFFFF;
                        1: ready_pat = 16'($urandom);
                        2: ready_pat = 16'($urandom | $urandom);
                        default: ready_pat = 16'($urandom & $urandom);
                    endcase
                end else begin
                    pat_pos++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        timing.short_time_us = RST_SHORT_TIME;
        timing.long_time_us = RST_LONG_TIME;
        timing.select_high_first_us = RST_SEL_HI_FIRST;
        timing.select_low_us = RST_SEL_LOW;
        timing.select_high_last_us = RST_SEL_HI_LAST;
        timing.off_hold_us = RST_OFF_HOLD;
        timing.device_address = RST_DEV_ADDR;
        wire_mode_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset timing.
        queue_req(1'b0, 8'd0);
        queue_req(1'b0, 8'd255);
        queue_req(1'b1, 8'd1);
        queue_req(1'b1, 8'd32);
        queue_req(1'b1, 8'd33);
        queue_req(1'b1, 8'd255);
        queue_req(1'b1, 8'h55);
        queue_req(1'b1, 8'd0);
        queue_req(1'b1, 8'd0);
        queue_req(1'b1, 8'd2);
        queue_req(1'b1, 8'd16);
        queue_req(1'b1, 8'd0);
        // Panel off does not restore one-wire mode, so the select sequence still follows.
        queue_req(1'b0, 8'hAA);
        queue_req(1'b1, 8'd31);
        queue_req(1'b1, 8'd128);
        queue_req(1'b1, 8'h40);
        queue_req(1'b1, 8'd0);
        queue_req(1'b1, 8'h80);
        queue_req(1'b0, 8'h7F);
        queue_req(1'b1, 8'd17);
        wait_idle();

        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(1'b1, 8'd0);
        queue_random(30);
        wait_idle();

        // All zero: every duration means hold, and the upper address bits are dropped.
        apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFF00);
        queue_req(1'b1, 8'd0);
        queue_random(30);
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            apply_config(rand_duration(), rand_duration(), rand_duration(), rand_duration(),
                         rand_duration(), rand_duration(), 16'($urandom_range(0, 65535)));
            hold_armed = (phase == 1);
            queue_random(32);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
